// ===== rtl/core/cmdf_pkg.sv =====
// cmdf_pkg: types and constants for the control message deframer
// used by control_message_deframer_core and its port checker; no dependencies
`default_nettype none

package cmdf_pkg;

  // parse phase of the deframer
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_COMMAND = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DISCARD = 3'd4
  } phase_t;

  // byte kinds as they leave the block
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_COMMAND = 3'd1;
  localparam logic [2:0] KIND_LENGTH  = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_DISCARD = 3'd4;

  // fault codes
  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_TOO_LONG = 2'd1;
  localparam logic [1:0] FAULT_TRUNC    = 2'd2;
  localparam logic [1:0] FAULT_OVERFLOW = 2'd3;

  // header layout: three little-endian words, body length is the third
  localparam logic [3:0] HDR_LEN_B0 = 4'd8;
  localparam logic [3:0] HDR_LEN_B1 = 4'd9;
  localparam logic [3:0] HDR_LEN_B2 = 4'd10;
  localparam logic [3:0] HDR_LAST   = 4'd11;

  // varint length groups
  localparam int GROUP_BITS = 7;
  localparam int MORE_BIT   = 7;

  // result word layout
  localparam int TDATA_W = 80;
  localparam int TUSER_W = 6;

endpackage : cmdf_pkg

`default_nettype wire

// ===== rtl/core/control_message_deframer_core.sv =====
// control_message_deframer_core: tags every byte of a control message
// (12-byte header, then packets of command, varint length and payload)
// depends on cmdf_pkg
//
// Usage:
//   in_*  : one message byte per word, header first, in_tdata[7:0].
//   out_* : one tagged word per input byte; tdata carries the byte, the
//           command, the packet length and the payload index; tuser the byte
//           kind, the end-of-packet flag and the fault code; tlast marks the
//           final byte of a message.
//   out_tvalid is registered and set at the accepting edge. A byte can be
//   taken every cycle: the parse state and the result register both update
//   at the accepting edge, and in_tready stays high while the result register
//   is empty or being drained in the same cycle.
//   When the receiver stalls, the result holds in the output register and
//   in_tready is low, so further bytes wait upstream; nothing is dropped.
//   Reset empties the output register and returns the parser to the start of
//   a message header with all counts at zero.
//   After a fault the rest of the message is passed out as discarded bytes
//   and parsing restarts at the next header.
`default_nettype none

module control_message_deframer_core #(
  parameter int LENGTH_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // in_tdata: [7:0] data_byte
  input  wire logic                         in_tvalid,
  output      logic                         in_tready,
  input  wire logic [7:0]                   in_tdata,
  // out_tdata: [7:0] byte_value, [15:8] command_code,
  //            [47:16] packet_length, [79:48] payload_index
  // out_tuser: [2:0] byte_kind, [3] last_of_packet, [5:4] fault
  // out_tlast: last_of_message
  output      logic                         out_tvalid,
  input  wire logic                         out_tready,
  output      logic [cmdf_pkg::TDATA_W-1:0] out_tdata,
  output      logic [cmdf_pkg::TUSER_W-1:0] out_tuser,
  output      logic                         out_tlast
);

  import cmdf_pkg::*;

  localparam int LW = LENGTH_WIDTH;
  localparam int EW = (LENGTH_WIDTH > 32) ? LENGTH_WIDTH : 32;

  // parse state
  phase_t           phase_r, phase_nxt;
  logic [3:0]       hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]      msg_left_r, msg_left_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [LW-1:0]    acc_r, acc_nxt;
  logic [LW-1:0]    pay_left_r, pay_left_nxt;

  // result register
  logic             out_valid_r;
  logic [2:0]       kind_r, kind_nxt;
  logic [7:0]       value_r;
  logic [7:0]       cmd_out_r, cmd_out_nxt;
  logic [31:0]      plen_r, plen_nxt;
  logic [31:0]      pidx_r, pidx_nxt;
  logic             lastp_r, lastp_nxt;
  logic             lastm_r, lastm_nxt;
  logic [1:0]       fault_r, fault_nxt;

  logic             accept;
  logic [31:0]      msg_dec;
  logic [LW-1:0]    pay_dec;
  logic [LW-1:0]    acc_shift;
  logic [LW-1:0]    pay_pos;
  logic             acc_ovf;
  logic [EW-1:0]    acc_shift_ext;
  logic [EW-1:0]    msg_dec_ext;
  logic [EW-1:0]    acc_ext;
  logic [EW-1:0]    pay_pos_ext;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign msg_dec   = msg_left_r - 32'd1;
  assign pay_dec   = pay_left_r - LW'(1);
  assign acc_ovf   = (acc_r >> (LW - GROUP_BITS)) != '0;
  assign acc_shift = {acc_r[LW-GROUP_BITS-1:0], in_tdata[GROUP_BITS-1:0]};
  assign pay_pos   = acc_r - pay_left_r;

  assign acc_shift_ext = EW'(acc_shift);
  assign msg_dec_ext   = EW'(msg_dec);
  assign acc_ext       = EW'(acc_r);
  assign pay_pos_ext   = EW'(pay_pos);

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    msg_left_nxt = msg_left_r;
    cmd_nxt      = cmd_r;
    acc_nxt      = acc_r;
    pay_left_nxt = pay_left_r;
    kind_nxt     = KIND_HEADER;
    cmd_out_nxt  = 8'd0;
    plen_nxt     = 32'd0;
    pidx_nxt     = 32'd0;
    lastp_nxt    = 1'b0;
    lastm_nxt    = 1'b0;
    fault_nxt    = FAULT_NONE;

    case (phase_r)
      PH_COMMAND: begin
        kind_nxt     = KIND_COMMAND;
        msg_left_nxt = msg_dec;
        cmd_nxt      = in_tdata;
        cmd_out_nxt  = in_tdata;
        acc_nxt      = '0;
        if (msg_dec == 32'd0) begin
          // message ends on the command byte
          fault_nxt = FAULT_TRUNC;
          lastm_nxt = 1'b1;
          phase_nxt = PH_HEADER;
        end else begin
          phase_nxt = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        kind_nxt     = KIND_LENGTH;
        cmd_out_nxt  = cmd_r;
        msg_left_nxt = msg_dec;
        if (acc_ovf) begin
          plen_nxt  = acc_ext[31:0];
          fault_nxt = FAULT_OVERFLOW;
          lastm_nxt = (msg_dec == 32'd0);
          phase_nxt = (msg_dec == 32'd0) ? PH_HEADER : PH_DISCARD;
        end else begin
          acc_nxt  = acc_shift;
          plen_nxt = acc_shift_ext[31:0];
          if (in_tdata[MORE_BIT]) begin
            if (msg_dec == 32'd0) begin
              fault_nxt = FAULT_TRUNC;
              lastm_nxt = 1'b1;
              phase_nxt = PH_HEADER;
            end
          end else if (acc_shift_ext > msg_dec_ext) begin
            fault_nxt = FAULT_TOO_LONG;
            lastm_nxt = (msg_dec == 32'd0);
            phase_nxt = (msg_dec == 32'd0) ? PH_HEADER : PH_DISCARD;
          end else if (acc_shift == '0) begin
            // zero-length packet ends on its last length group
            lastp_nxt = 1'b1;
            lastm_nxt = (msg_dec == 32'd0);
            phase_nxt = (msg_dec == 32'd0) ? PH_HEADER : PH_COMMAND;
          end else begin
            pay_left_nxt = acc_shift;
            phase_nxt    = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        kind_nxt     = KIND_PAYLOAD;
        cmd_out_nxt  = cmd_r;
        plen_nxt     = acc_ext[31:0];
        pidx_nxt     = pay_pos_ext[31:0];
        msg_left_nxt = msg_dec;
        pay_left_nxt = pay_dec;
        if (pay_dec == '0) begin
          lastp_nxt = 1'b1;
          lastm_nxt = (msg_dec == 32'd0);
          phase_nxt = (msg_dec == 32'd0) ? PH_HEADER : PH_COMMAND;
        end
      end
      PH_DISCARD: begin
        kind_nxt     = KIND_DISCARD;
        msg_left_nxt = msg_dec;
        if (msg_dec == 32'd0) begin
          lastm_nxt = 1'b1;
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
        kind_nxt = KIND_HEADER;
        // body length word lands byte lane by byte lane
        case (hdr_cnt_r)
          4'd0:       msg_left_nxt = 32'd0;
          HDR_LEN_B0: msg_left_nxt[7:0]   = in_tdata;
          HDR_LEN_B1: msg_left_nxt[15:8]  = in_tdata;
          HDR_LEN_B2: msg_left_nxt[23:16] = in_tdata;
          HDR_LAST:   msg_left_nxt[31:24] = in_tdata;
          default:    msg_left_nxt = msg_left_r;
        endcase
        if (hdr_cnt_r >= HDR_LAST) begin
          hdr_cnt_nxt = 4'd0;
          if ({in_tdata, msg_left_r[23:0]} == 32'd0) begin
            lastm_nxt = 1'b1;
            phase_nxt = PH_HEADER;
          end else begin
            phase_nxt = PH_COMMAND;
          end
        end else begin
          hdr_cnt_nxt = hdr_cnt_r + 4'd1;
          phase_nxt   = PH_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_cnt_r  <= 4'd0;
      msg_left_r <= 32'd0;
      cmd_r      <= 8'd0;
      acc_r      <= '0;
      pay_left_r <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      msg_left_r <= msg_left_nxt;
      cmd_r      <= cmd_nxt;
      acc_r      <= acc_nxt;
      pay_left_r <= pay_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= kind_nxt;
      value_r   <= in_tdata;
      cmd_out_r <= cmd_out_nxt;
      plen_r    <= plen_nxt;
      pidx_r    <= pidx_nxt;
      lastp_r   <= lastp_nxt;
      lastm_r   <= lastm_nxt;
      fault_r   <= fault_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {pidx_r, plen_r, cmd_out_r, value_r};
  assign out_tuser  = {fault_r, lastp_r, kind_r};
  assign out_tlast  = lastm_r;

endmodule : control_message_deframer_core

`default_nettype wire

// ===== rtl/core/cmdf_chk.sv =====
// cmdf_chk: port-level checks on the deframer result channel, bound to the top level
// depends on cmdf_pkg and control_message_deframer_core
`default_nettype none

module cmdf_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [cmdf_pkg::TDATA_W-1:0] out_tdata,
  input wire logic [cmdf_pkg::TUSER_W-1:0] out_tuser,
  input wire logic                         out_tlast
);

  import cmdf_pkg::*;

  // a stalled word holds still
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // faults are only found on packet header bytes
  a_fault_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[5:4] != FAULT_NONE |->
      out_tuser[2:0] == KIND_COMMAND || out_tuser[2:0] == KIND_LENGTH)
    else $error("fault flagged on a byte that is not a packet header");

  // payload index is zero outside payload bytes
  a_pidx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] != KIND_PAYLOAD |-> out_tdata[79:48] == 32'd0)
    else $error("payload index set on a non-payload byte");

  // packets end on a length group or a payload byte, never with a fault
  a_lastp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |->
      (out_tuser[2:0] == KIND_LENGTH || out_tuser[2:0] == KIND_PAYLOAD) &&
      out_tuser[5:4] == FAULT_NONE)
    else $error("end of packet on an unexpected byte");

  // header and discarded bytes carry no command and no packet length
  a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:0] == KIND_HEADER || out_tuser[2:0] == KIND_DISCARD) |->
      out_tdata[15:8] == 8'd0 && out_tdata[47:16] == 32'd0)
    else $error("command or length set on a header or discarded byte");

endmodule : cmdf_chk

bind control_message_deframer_core cmdf_chk u_cmdf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
